>>> rtl/rfm_pkg.sv
// Shared types and constants for the radial falloff mask generator.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rfm_pkg;

    localparam int RAD_W       = 8;
    localparam int IDX_W       = 9;
    localparam int ADDR_W      = 18;
    localparam int SQ_W        = 20;
    localparam int ROOT_W      = 10;
    localparam int REM_W       = 11;
    localparam int SQRT_STEPS  = SQ_W / 2;
    localparam logic [RAD_W-1:0] MAX_RADIUS   = 8'd200;
    localparam logic [RAD_W-1:0] RESET_RADIUS = 8'd1;

    typedef struct packed {
        logic [SQ_W-1:0]   rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [ADDR_W-1:0] addr;
        logic              grid;
    } sqrt_cell_t;

endpackage
`default_nettype wire

>>> rtl/radial_falloff_mask_generator.sv
// Top level of the radial falloff mask generator: radius register, front
// stages, square root cell chain and output register. Uses rfm_pkg,
// rfm_front and rfm_sqrt_cell.
//
// The block takes one coordinate item per cycle and returns one mask pixel
// per item, in order, after it passes fourteen register stages: three front
// stages, ten square root cells (one root bit each) and the output register,
// the first of which loads at the accepting edge. Throughput is one item per
// clock as long as m_ready stays high. The radius register must only be
// written while no item is in flight; a zero write is ignored and writes
// above 200 store 200.
`default_nettype none
module radial_falloff_mask_generator (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [rfm_pkg::RAD_W-1:0]   cfg_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [rfm_pkg::IDX_W-1:0]   s_row_index,
    input  wire logic [rfm_pkg::IDX_W-1:0]   s_col_index,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [rfm_pkg::RAD_W-1:0]        m_intensity,
    output logic                             m_inside_res,
    output logic [rfm_pkg::ADDR_W-1:0]       m_pixel_address,
    output logic                             m_in_grid
);

    logic [rfm_pkg::RAD_W-1:0] radius_reg;
    logic [rfm_pkg::RAD_W-1:0] radius_next;

    rfm_pkg::sqrt_cell_t chain_data [rfm_pkg::SQRT_STEPS+1];
    logic                chain_valid [rfm_pkg::SQRT_STEPS+1];
    logic                chain_ready [rfm_pkg::SQRT_STEPS+1];

    logic                       out_valid_reg;
    logic                       out_load;
    logic [rfm_pkg::ROOT_W-1:0] root_dist;
    logic                       inside_next;
    logic [rfm_pkg::RAD_W-1:0]  intensity_next;
    logic [rfm_pkg::RAD_W-1:0]  intensity_reg;
    logic                       inside_reg;
    logic [rfm_pkg::ADDR_W-1:0] addr_reg;
    logic                       grid_reg;

    assign cfg_ready = 1'b1;

    always_comb begin
        radius_next = radius_reg;
        if (cfg_data != '0) begin
            radius_next = (cfg_data > rfm_pkg::MAX_RADIUS) ? rfm_pkg::MAX_RADIUS : cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= rfm_pkg::RESET_RADIUS;
        end else if (cfg_valid) begin
            radius_reg <= radius_next;
        end
    end

    rfm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .radius    (radius_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .row_index (s_row_index),
        .col_index (s_col_index),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < rfm_pkg::SQRT_STEPS; i++) begin : g_cell
        rfm_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    assign out_load = !out_valid_reg || m_ready;
    assign chain_ready[rfm_pkg::SQRT_STEPS] = out_load;

    always_comb begin
        root_dist      = chain_data[rfm_pkg::SQRT_STEPS].root;
        inside_next    = root_dist <= rfm_pkg::ROOT_W'(radius_reg);
        intensity_next = inside_next ? (radius_reg - root_dist[rfm_pkg::RAD_W-1:0]) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= chain_valid[rfm_pkg::SQRT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && chain_valid[rfm_pkg::SQRT_STEPS]) begin
            intensity_reg <= intensity_next;
            inside_reg    <= inside_next;
            addr_reg      <= chain_data[rfm_pkg::SQRT_STEPS].addr;
            grid_reg      <= chain_data[rfm_pkg::SQRT_STEPS].grid;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_intensity     = intensity_reg;
    assign m_inside_res    = inside_reg;
    assign m_pixel_address = addr_reg;
    assign m_in_grid       = grid_reg;

endmodule
`default_nettype wire

>>> rtl/rfm_front.sv
// Front stages: centers the indices, forms address and grid flag, squares
// and sums the offsets. Depends on rfm_pkg.
`default_nettype none
module rfm_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [rfm_pkg::RAD_W-1:0]   radius,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [rfm_pkg::IDX_W-1:0]   row_index,
    input  wire logic [rfm_pkg::IDX_W-1:0]   col_index,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output rfm_pkg::sqrt_cell_t              out_data
);

    logic [rfm_pkg::IDX_W-1:0]  centre;
    logic [rfm_pkg::IDX_W-1:0]  side;
    logic [rfm_pkg::IDX_W-1:0]  dx_next;
    logic [rfm_pkg::IDX_W-1:0]  dy_next;
    logic [rfm_pkg::ADDR_W-1:0] addr_next;
    logic                       grid_next;

    logic                       s1_valid_reg;
    logic [rfm_pkg::IDX_W-1:0]  dx_reg;
    logic [rfm_pkg::IDX_W-1:0]  dy_reg;
    logic [rfm_pkg::ADDR_W-1:0] s1_addr_reg;
    logic                       s1_grid_reg;
    logic                       s1_ready;

    logic                       s2_valid_reg;
    logic [rfm_pkg::SQ_W-1:0]   dx_sq_reg;
    logic [rfm_pkg::SQ_W-1:0]   dy_sq_reg;
    logic [rfm_pkg::ADDR_W-1:0] s2_addr_reg;
    logic                       s2_grid_reg;
    logic                       s2_ready;

    logic                       s3_valid_reg;
    logic [rfm_pkg::SQ_W-1:0]   sum_reg;
    logic [rfm_pkg::ADDR_W-1:0] s3_addr_reg;
    logic                       s3_grid_reg;
    logic                       s3_ready;

    always_comb begin
        centre    = rfm_pkg::IDX_W'(radius) + 9'd1;
        side      = {centre[rfm_pkg::IDX_W-2:0], 1'b0};
        dx_next   = (row_index >= centre) ? (row_index - centre) : (centre - row_index);
        dy_next   = (col_index >= centre) ? (col_index - centre) : (centre - col_index);
        addr_next = rfm_pkg::ADDR_W'(rfm_pkg::ADDR_W'(row_index) * rfm_pkg::ADDR_W'(side))
                  + rfm_pkg::ADDR_W'(col_index);
        grid_next = (row_index < side) && (col_index < side);
    end

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            s1_addr_reg <= addr_next;
            s1_grid_reg <= grid_next;
        end
        if (s2_ready && s1_valid_reg) begin
            dx_sq_reg   <= rfm_pkg::SQ_W'(dx_reg) * rfm_pkg::SQ_W'(dx_reg);
            dy_sq_reg   <= rfm_pkg::SQ_W'(dy_reg) * rfm_pkg::SQ_W'(dy_reg);
            s2_addr_reg <= s1_addr_reg;
            s2_grid_reg <= s1_grid_reg;
        end
        if (s3_ready && s2_valid_reg) begin
            sum_reg     <= dx_sq_reg + dy_sq_reg;
            s3_addr_reg <= s2_addr_reg;
            s3_grid_reg <= s2_grid_reg;
        end
    end

    assign out_valid     = s3_valid_reg;
    assign out_data.rad  = sum_reg;
    assign out_data.rem  = '0;
    assign out_data.root = '0;
    assign out_data.addr = s3_addr_reg;
    assign out_data.grid = s3_grid_reg;

endmodule
`default_nettype wire

>>> rtl/rfm_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit from the next
// two radicand bits and passes the item on. Depends on rfm_pkg.
`default_nettype none
module rfm_sqrt_cell (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rfm_pkg::sqrt_cell_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rfm_pkg::sqrt_cell_t       out_data
);

    logic                 valid_reg;
    rfm_pkg::sqrt_cell_t  data_reg;
    rfm_pkg::sqrt_cell_t  data_next;
    logic [rfm_pkg::REM_W+1:0] cand;
    logic [rfm_pkg::REM_W+1:0] trial;
    logic [rfm_pkg::REM_W+2:0] diff;

    always_comb begin
        cand      = {in_data.rem, in_data.rad[rfm_pkg::SQ_W-1 -: 2]};
        trial     = {1'b0, in_data.root, 2'b01};
        diff      = {1'b0, cand} - {1'b0, trial};
        data_next = in_data;
        data_next.rad = {in_data.rad[rfm_pkg::SQ_W-3:0], 2'b00};
        if (!diff[rfm_pkg::REM_W+2]) begin
            data_next.rem  = diff[rfm_pkg::REM_W-1:0];
            data_next.root = {in_data.root[rfm_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            data_next.rem  = cand[rfm_pkg::REM_W-1:0];
            data_next.root = {in_data.root[rfm_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

>>> rtl/rfm_checker.sv
// Port-level checks for the radial falloff mask generator, bound to the top
// level. Uses rfm_pkg for widths and the maximum radius.
`default_nettype none
module rfm_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire logic [rfm_pkg::RAD_W-1:0]   m_intensity,
    input  wire logic                        m_inside_res,
    input  wire logic [rfm_pkg::ADDR_W-1:0]  m_pixel_address,
    input  wire logic                        m_in_grid
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_intensity) && $stable(m_inside_res)
            && $stable(m_pixel_address) && $stable(m_in_grid))
        else $error("Result item changed while stalled.");

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_inside_res |-> m_intensity == '0)
        else $error("Nonzero intensity outside the circle.");

    a_intensity_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_intensity <= rfm_pkg::MAX_RADIUS)
        else $error("Intensity above the maximum radius.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

endmodule

bind radial_falloff_mask_generator rfm_checker u_rfm_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_intensity     (m_intensity),
    .m_inside_res    (m_inside_res),
    .m_pixel_address (m_pixel_address),
    .m_in_grid       (m_in_grid)
);
`default_nettype wire
